// ----- rtl/core/packet_reorder_buffer_top_assert.svh -----
// Assertion macros for the packet reorder buffer.
`ifndef PACKET_REORDER_BUFFER_TOP_ASSERT_SVH
`define PACKET_REORDER_BUFFER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define PRB_ASSERT_HOLDS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("prb: invariant violated");

`define PRB_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prb: implication violated");

`define PRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prb: next-cycle check violated");

`else

`define PRB_ASSERT_HOLDS(label, expr)
`define PRB_ASSERT_IMPLIES(label, ante, cons)
`define PRB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/core/prb_pkg.sv -----
// Shared types, constants and payload conversion for the packet reorder buffer.
package prb_pkg;

    localparam int SEQ_W          = 14;
    localparam int HEAD_W         = 64;
    localparam int TAIL_W         = 32;
    localparam int WINDOW_DEFAULT = 32;
    localparam int MAX_OUT        = 32;
    localparam int CNT_W          = 6;

    localparam logic [SEQ_W-1:0] FIRST_SEQ_RESET = 14'd1;

    localparam logic [7:0] BYTE_EQUALS  = 8'd61;
    localparam logic [7:0] BYTE_PLUS    = 8'd43;
    localparam logic [7:0] BYTE_NEWLINE = 8'd10;
    localparam logic [7:0] BYTE_NUL     = 8'd0;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_DROP    = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [HEAD_W-1:0] payload_head;
        logic [TAIL_W-1:0] payload_tail;
    } prb_in_t;

    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  out_seq;
        logic [HEAD_W-1:0] out_head;
        logic [TAIL_W-1:0] out_tail;
        logic              last;
    } prb_out_t;

    function automatic logic [HEAD_W-1:0] convert_bytes(input logic [HEAD_W-1:0] v);
        logic [HEAD_W-1:0] r;
        logic [7:0]        b;
        r = '0;
        for (int i = 0; i < HEAD_W / 8; i++)
        begin
            b = v[8*i +: 8];
            if (b == BYTE_EQUALS)
            begin
                b = BYTE_NEWLINE;
            end
            else if (b == BYTE_PLUS)
            begin
                b = BYTE_NUL;
            end
            r[8*i +: 8] = b;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/prb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module prb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/packet_reorder_buffer_top.sv -----
// Packet reorder buffer top level: window store, drain sequencer and output register.
// An accepted packet is checked against the window [expected, expected + WINDOW) and
// either stored in the slot RAM or reported at once as a drop (kind 1). Whenever the
// slot of the expected number holds a packet, the held packets are delivered in order
// (kind 0), at most 32 results per input; 'last' marks the final one. A dropped input
// is accepted, then window-checked with the drop result loaded; a stored input is
// accepted, window-checked and written to its slot, and then the expected slot is
// examined. Each delivered result needs a slot RAM read and then an output load, since
// the slot RAM has registered read data. Stalls on the output hold the drop result and
// each delivery back. A write on the cfg channel restarts the block with a new expected
// sequence number; slot valid bits live in flops, so there is no clearing pass after
// reset.
module packet_reorder_buffer_top #(
    parameter int WINDOW = prb_pkg::WINDOW_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  prb_pkg::prb_in_t           in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output prb_pkg::prb_out_t          out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [prb_pkg::SEQ_W-1:0]  cfg_data
);

    import prb_pkg::*;

    localparam int IDX_W = $clog2(WINDOW);
    localparam int SLOT_W = HEAD_W + TAIL_W;
    localparam logic [IDX_W:0]   WIN_WIDE = (IDX_W + 1)'(WINDOW);
    localparam logic [IDX_W-1:0] IDX_TOP  = IDX_W'(WINDOW - 1);
    localparam logic [SEQ_W-1:0] WIN_SEQ  = SEQ_W'(WINDOW);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_OUT);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [SEQ_W-1:0]  expected_reg, expected_next;
    logic [IDX_W-1:0]  base_reg, base_next;
    logic [WINDOW-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    prb_in_t           hold_reg, hold_next;
    logic              out_valid_reg, out_valid_next;
    prb_out_t          out_data_reg, out_data_next;

    logic [SEQ_W-1:0]  seq_gap;
    logic [IDX_W:0]    idx_sum;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  base_inc;
    logic              drop;
    logic              out_free;
    logic              emit_fire;
    logic              emit_last;
    logic [CNT_W-1:0]  cnt_inc;

    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [SLOT_W-1:0] ram_rd_data;
    logic [HEAD_W-1:0] tail_conv;
    logic [HEAD_W-1:0] rd_tail_conv;

    prb_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (WINDOW)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx),
        .wr_data ({hold_reg.payload_head, hold_reg.payload_tail}),
        .rd_en   (ram_rd_en),
        .rd_addr (base_reg),
        .rd_data (ram_rd_data)
    );

    assign seq_gap  = hold_reg.seq - expected_reg;
    assign idx_sum  = {1'b0, base_reg} + {1'b0, seq_gap[IDX_W-1:0]};
    assign idx      = (idx_sum >= WIN_WIDE) ? IDX_W'(idx_sum - WIN_WIDE) : idx_sum[IDX_W-1:0];
    assign base_inc = (base_reg == IDX_TOP) ? '0 : base_reg + 1'b1;
    assign drop     = (seq_gap >= WIN_SEQ) || valid_reg[idx];
    assign out_free = !out_valid_reg || out_ready;
    assign cnt_inc  = cnt_reg + 1'b1;

    assign emit_fire = (state_reg == S_EMIT) && out_free;
    assign emit_last = !valid_reg[base_inc] || (cnt_inc == CNT_MAX);

    assign tail_conv    = convert_bytes({{(HEAD_W-TAIL_W){1'b0}}, hold_reg.payload_tail});
    assign rd_tail_conv = convert_bytes({{(HEAD_W-TAIL_W){1'b0}}, ram_rd_data[TAIL_W-1:0]});

    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        expected_next  = expected_reg;
        base_next      = base_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    expected_next = cfg_data;
                    base_next     = '0;
                    valid_next    = '0;
                end
                else if (in_valid)
                begin
                    hold_next  = in_data;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (drop)
                begin
                    if (out_free)
                    begin
                        out_valid_next         = 1'b1;
                        out_data_next.kind     = KIND_DROP;
                        out_data_next.out_seq  = hold_reg.seq;
                        out_data_next.out_head = convert_bytes(hold_reg.payload_head);
                        out_data_next.out_tail = tail_conv[TAIL_W-1:0];
                        out_data_next.last     = !valid_reg[base_reg];
                        cnt_next               = CNT_W'(1);
                        state_next             = valid_reg[base_reg] ? S_READ : S_IDLE;
                    end
                end
                else
                begin
                    ram_wr_en       = 1'b1;
                    valid_next[idx] = 1'b1;
                    cnt_next        = '0;
                    state_next      = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = valid_reg[base_reg] ? S_READ : S_IDLE;
            end
            S_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.kind     = KIND_DELIVER;
                    out_data_next.out_seq  = expected_reg;
                    out_data_next.out_head = convert_bytes(ram_rd_data[SLOT_W-1:TAIL_W]);
                    out_data_next.out_tail = rd_tail_conv[TAIL_W-1:0];
                    out_data_next.last     = emit_last;
                    valid_next[base_reg]   = 1'b0;
                    expected_next          = expected_reg + 1'b1;
                    base_next              = base_inc;
                    cnt_next               = cnt_inc;
                    state_next             = emit_last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            expected_reg  <= FIRST_SEQ_RESET;
            base_reg      <= '0;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            expected_reg  <= expected_next;
            base_reg      <= base_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        out_data_reg <= out_data_next;
    end

`include "packet_reorder_buffer_top_assert.svh"

    `PRB_ASSERT_HOLDS(a_base_in_ring, base_reg <= IDX_TOP)
    `PRB_ASSERT_HOLDS(a_cnt_capped, cnt_reg <= CNT_MAX)
    `PRB_ASSERT_IMPLIES(a_emit_from_valid_slot, emit_fire, valid_reg[base_reg])
    `PRB_ASSERT_NEXT(a_emit_advances, emit_fire, expected_reg == $past(expected_reg) + 1'b1)

endmodule
